@@ src/gmos_pkg.sv @@
// gmos_pkg: shared widths, constants, item and handshake types for the
// grouped mean offset scaler. No dependencies.
package gmos_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int DIVISOR_W   = 16;
    localparam int OUT_W       = 33;
    localparam int CFG_IDX_W   = 8;

    // arithmetic constants
    localparam int GROUP_LENGTH = 50;
    localparam int FRAC_BITS    = 8;
    localparam int SCALE_SHIFT  = 8;
    localparam int CNT_W        = 8;
    // running value stays within the sample range times GROUP_LENGTH
    localparam int RV_W         = 24;
    // widest dividend: (baseline - mean) in fixed point, shifted by the scale
    localparam int DIV_W        = RV_W + FRAC_BITS + SCALE_SHIFT + 2;
    localparam int ITER_W       = $clog2(DIV_W);

    // group mean by reciprocal: exact truncation for any RV_W-bit magnitude
    localparam int     GRP_SHIFT      = RV_W + $clog2(GROUP_LENGTH);
    localparam int     RECIP_W        = RV_W + 1;
    localparam int     GRP_PROD_W     = RV_W + RECIP_W;
    localparam longint GRP_RECIP_FULL = ((longint'(1) <<< GRP_SHIFT)
                                        + longint'(GROUP_LENGTH - 1))
                                        / longint'(GROUP_LENGTH);
    localparam logic [RECIP_W-1:0] GRP_RECIP = RECIP_W'(GRP_RECIP_FULL);

    // item queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = CFG_IDX_W'(1);

    // reset values and saturation bounds
    localparam logic [DIVISOR_W-1:0] SCALE_RESET = DIVISOR_W'(256);
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // one classified item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       seed;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_W-1:0]  dividend;
        logic [DIVISOR_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DIV_W-1:0]  quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GROUP_DIV,
        BK_GROUP_MEAN,
        BK_MEAN_DIV,
        BK_SCALE_DIV,
        BK_OUT
    } back_state_t;

endpackage

@@ src/gmos_front.sv @@
// gmos_front: input channel, marks each sample as block seed or accumulate
// and pushes it into the item queue. Depends on gmos_pkg.
module gmos_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [gmos_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_sample,
    input  gmos_pkg::q_stat_t                   q_stat,
    output logic                                push,
    output gmos_pkg::item_t                     push_item
);

    logic started_reg;
    logic started_next;

    // accept whenever the queue has room
    assign in_ready = !q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // classify the item
    always_comb
    begin
        push_item.sample = sample;
        push_item.last   = last_sample;
        push_item.seed   = !started_reg;
    end

    // block tracking: a last sample ends the block
    always_comb
    begin
        started_next = started_reg;
        if (push)
        begin
            started_next = !last_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
        end
    end

endmodule

@@ src/gmos_queue.sv @@
// gmos_queue: short item fifo that decouples the front from the back.
// Depends on gmos_pkg.
module gmos_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gmos_pkg::item_t    push_item,
    input  logic               pop,
    output gmos_pkg::item_t    pop_item,
    output gmos_pkg::q_stat_t  q_stat
);

    gmos_pkg::item_t entries [gmos_pkg::QUEUE_DEPTH];

    logic [gmos_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [gmos_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [gmos_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [gmos_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [gmos_pkg::QPTR_W:0]   count_reg;
    logic [gmos_pkg::QPTR_W:0]   count_next;

    // status
    always_comb
    begin
        q_stat.full  = (count_reg == (gmos_pkg::QPTR_W + 1)'(gmos_pkg::QUEUE_DEPTH));
        q_stat.empty = (count_reg == '0);
    end

    assign pop_item = entries[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + gmos_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + gmos_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (gmos_pkg::QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (gmos_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/gmos_div.sv @@
// gmos_div: iterative restoring divider, one quotient bit per cycle,
// signed dividend, unsigned nonzero divisor, truncates toward zero.
// Depends on gmos_pkg.
module gmos_div (
    input  logic                clk,
    input  logic                rst_n,
    input  gmos_pkg::div_req_t  req,
    output gmos_pkg::div_rsp_t  rsp
);

    logic                              busy_reg;
    logic                              fin_reg;
    logic                              done_reg;
    logic [gmos_pkg::ITER_W-1:0]       iter_reg;
    logic [gmos_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [gmos_pkg::DIV_W-1:0]        quo_reg;
    logic [gmos_pkg::DIVISOR_W-1:0]    den_reg;
    logic                              neg_reg;
    logic signed [gmos_pkg::DIV_W-1:0] result_reg;

    logic [gmos_pkg::DIVISOR_W:0]      shifted;
    logic [gmos_pkg::DIVISOR_W:0]      trial;
    logic                              ge;
    logic [gmos_pkg::DIVISOR_W-1:0]    rem_step;
    logic [gmos_pkg::DIV_W-1:0]        magnitude;
    logic                              last_iter;

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[gmos_pkg::DIV_W-1]};
        ge        = (shifted >= {1'b0, den_reg});
        trial     = shifted - {1'b0, den_reg};
        rem_step  = ge ? trial[gmos_pkg::DIVISOR_W-1:0] : shifted[gmos_pkg::DIVISOR_W-1:0];
        magnitude = req.dividend[gmos_pkg::DIV_W-1] ? (-req.dividend) : req.dividend;
        last_iter = (iter_reg == gmos_pkg::ITER_W'(gmos_pkg::DIV_W - 1));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && last_iter;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + gmos_pkg::ITER_W'(1);
                if (last_iter)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= magnitude;
            den_reg <= req.divisor;
            neg_reg <= req.dividend[gmos_pkg::DIV_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[gmos_pkg::DIV_W-2:0], ge};
        end
        if (fin_reg)
        begin
            result_reg <= neg_reg ? (-quo_reg) : quo_reg;
        end
    end

    always_comb
    begin
        rsp.busy     = busy_reg || fin_reg;
        rsp.done     = done_reg;
        rsp.quotient = result_reg;
    end

endmodule

@@ src/gmos_back.sv @@
// gmos_back: executes queued items: accumulation, group division, block mean,
// offset and scale division, saturation, result register.
// Depends on gmos_pkg and drives gmos_div through div_req_t.
module gmos_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gmos_pkg::q_stat_t                     q_stat,
    input  gmos_pkg::item_t                       pop_item,
    output logic                                  pop,
    input  logic signed [gmos_pkg::SAMPLE_W-1:0]  baseline,
    input  logic [gmos_pkg::DIVISOR_W-1:0]        scale_divisor,
    output gmos_pkg::div_req_t                    div_req,
    input  gmos_pkg::div_rsp_t                    div_rsp,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [gmos_pkg::OUT_W-1:0]     scaled_level
);

    gmos_pkg::back_state_t state_reg;
    gmos_pkg::back_state_t state_next;

    logic signed [gmos_pkg::RV_W-1:0]   rv_reg;
    logic [gmos_pkg::CNT_W-1:0]         count_reg;
    logic                               last_pend_reg;
    logic [gmos_pkg::OUT_W-1:0]         res_reg;
    logic                               out_valid_reg;
    logic signed [gmos_pkg::OUT_W-1:0]  out_data_reg;

    logic signed [gmos_pkg::RV_W-1:0]   sample_ext;
    logic signed [gmos_pkg::RV_W-1:0]   acc_rv;
    logic [gmos_pkg::CNT_W-1:0]         cnt_inc;
    logic [gmos_pkg::CNT_W-1:0]         acc_cnt;
    logic                               group_end;
    logic                               item_here;
    logic [gmos_pkg::RV_W-1:0]          rv_mag;
    logic [gmos_pkg::GRP_PROD_W-1:0]    grp_prod;
    logic [gmos_pkg::RV_W-1:0]          grp_mag;
    logic signed [gmos_pkg::RV_W-1:0]   grp_quot;
    logic signed [gmos_pkg::DIV_W-1:0]  mean_val;
    logic signed [gmos_pkg::DIV_W-1:0]  base_wide;
    logic signed [gmos_pkg::DIV_W-1:0]  diff;
    logic [gmos_pkg::DIVISOR_W-1:0]     scale_eff;
    logic [gmos_pkg::DIV_W-gmos_pkg::OUT_W:0] high_bits;
    logic [gmos_pkg::OUT_W-1:0]         sat;
    logic                               slot_free;

    // running value in fixed point, widened to the divider
    function automatic logic signed [gmos_pkg::DIV_W-1:0] mean_dividend(
        input logic signed [gmos_pkg::RV_W-1:0] rv
    );
        logic signed [gmos_pkg::DIV_W-1:0] wide;
        wide = {{(gmos_pkg::DIV_W - gmos_pkg::RV_W){rv[gmos_pkg::RV_W-1]}}, rv};
        return wide <<< gmos_pkg::FRAC_BITS;
    endfunction

    // accumulation and classification of the head item
    always_comb
    begin
        item_here  = (state_reg == gmos_pkg::BK_IDLE) && !q_stat.empty;
        sample_ext = {{(gmos_pkg::RV_W - gmos_pkg::SAMPLE_W){pop_item.sample[gmos_pkg::SAMPLE_W-1]}},
                      pop_item.sample};
        cnt_inc    = count_reg + gmos_pkg::CNT_W'(1);
        acc_rv     = pop_item.seed ? sample_ext : (rv_reg + sample_ext);
        acc_cnt    = pop_item.seed ? '0 : cnt_inc;
        group_end  = !pop_item.seed && (cnt_inc == gmos_pkg::CNT_W'(gmos_pkg::GROUP_LENGTH - 1));
    end

    // group mean by reciprocal multiplication, truncating toward zero
    always_comb
    begin
        rv_mag   = rv_reg[gmos_pkg::RV_W-1] ? $unsigned(-rv_reg) : $unsigned(rv_reg);
        grp_prod = gmos_pkg::GRP_PROD_W'(rv_mag) * gmos_pkg::GRP_PROD_W'(gmos_pkg::GRP_RECIP);
        grp_mag  = gmos_pkg::RV_W'(grp_prod >> gmos_pkg::GRP_SHIFT);
        grp_quot = rv_reg[gmos_pkg::RV_W-1] ? -$signed(grp_mag) : $signed(grp_mag);
    end

    // offset, scale and saturation
    always_comb
    begin
        // counter is clear after a group end, so the block mean divides by one
        mean_val  = (state_reg == gmos_pkg::BK_GROUP_MEAN) ? mean_dividend(rv_reg)
                                                           : div_rsp.quotient;
        base_wide = {{(gmos_pkg::DIV_W - gmos_pkg::SAMPLE_W){baseline[gmos_pkg::SAMPLE_W-1]}},
                     baseline} <<< gmos_pkg::FRAC_BITS;
        diff      = base_wide - mean_val;
        scale_eff = (scale_divisor == '0) ? gmos_pkg::DIVISOR_W'(1) : scale_divisor;
        high_bits = div_rsp.quotient[gmos_pkg::DIV_W-1:gmos_pkg::OUT_W-1];
        if ((&high_bits) || !(|high_bits))
        begin
            sat = div_rsp.quotient[gmos_pkg::OUT_W-1:0];
        end
        else if (div_rsp.quotient[gmos_pkg::DIV_W-1])
        begin
            sat = gmos_pkg::OUT_MIN;
        end
        else
        begin
            sat = gmos_pkg::OUT_MAX;
        end
        slot_free = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gmos_pkg::BK_IDLE:
            begin
                if (item_here && group_end)
                begin
                    state_next = gmos_pkg::BK_GROUP_DIV;
                end
                else if (item_here && pop_item.last)
                begin
                    state_next = gmos_pkg::BK_MEAN_DIV;
                end
            end
            gmos_pkg::BK_GROUP_DIV:
            begin
                state_next = last_pend_reg ? gmos_pkg::BK_GROUP_MEAN : gmos_pkg::BK_IDLE;
            end
            gmos_pkg::BK_GROUP_MEAN:
            begin
                state_next = gmos_pkg::BK_SCALE_DIV;
            end
            gmos_pkg::BK_MEAN_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = gmos_pkg::BK_SCALE_DIV;
                end
            end
            gmos_pkg::BK_SCALE_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = gmos_pkg::BK_OUT;
                end
            end
            gmos_pkg::BK_OUT:
            begin
                if (slot_free)
                begin
                    state_next = gmos_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = gmos_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs: queue pop and divider requests
    always_comb
    begin
        pop              = item_here;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            gmos_pkg::BK_IDLE:
            begin
                if (item_here && !group_end && pop_item.last)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mean_dividend(acc_rv);
                    div_req.divisor  = gmos_pkg::DIVISOR_W'(acc_cnt) + gmos_pkg::DIVISOR_W'(1);
                end
            end
            gmos_pkg::BK_GROUP_DIV:
            begin
            end
            gmos_pkg::BK_GROUP_MEAN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = diff <<< gmos_pkg::SCALE_SHIFT;
                div_req.divisor  = scale_eff;
            end
            gmos_pkg::BK_MEAN_DIV:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = diff <<< gmos_pkg::SCALE_SHIFT;
                    div_req.divisor  = scale_eff;
                end
            end
            gmos_pkg::BK_SCALE_DIV:
            begin
            end
            gmos_pkg::BK_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmos_pkg::BK_IDLE;
            rv_reg        <= '0;
            count_reg     <= '0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (item_here)
            begin
                rv_reg        <= acc_rv;
                count_reg     <= group_end ? '0 : acc_cnt;
                last_pend_reg <= pop_item.last;
            end
            else if (state_reg == gmos_pkg::BK_GROUP_DIV)
            begin
                rv_reg <= grp_quot;
            end
            if ((state_reg == gmos_pkg::BK_OUT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == gmos_pkg::BK_SCALE_DIV) && div_rsp.done)
        begin
            res_reg <= sat;
        end
        if ((state_reg == gmos_pkg::BK_OUT) && slot_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scaled_level = out_data_reg;

endmodule

@@ src/grouped_mean_offset_scaler_unit.sv @@
// grouped_mean_offset_scaler_unit: top level, configuration registers, front,
// item queue, back and shared divider. Depends on gmos_pkg, gmos_front,
// gmos_queue, gmos_div and gmos_back.
//
//  channel  | signals                            | direction
//  ---------+------------------------------------+-----------
//  input    | in_valid, in_ready, sample,        | into block
//           | last_sample                        |
//  result   | out_valid, out_ready, scaled_level | out of block
//  config   | cfg_valid, cfg_ready, cfg_index,   | into block
//           | cfg_data                           |
//
// A plain sample is popped and accumulated in the idle state; one closing a
// group of 50 adds a reciprocal multiply. A last sample adds two divisions
// (mean, then scale) and a result load, or, when it also closes a group, the
// multiply, the mean step, the scale division and the load. The four-entry
// queue keeps taking samples while the back end works; a held result stalls it.
// Reset clears control state, baseline to 0, scale to 1.0; config every cycle.
module grouped_mean_offset_scaler_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [gmos_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                   last_sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [gmos_pkg::OUT_W-1:0]      scaled_level,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gmos_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gmos_pkg::DIVISOR_W-1:0]         cfg_data
);

    logic signed [gmos_pkg::SAMPLE_W-1:0] baseline_reg;
    logic [gmos_pkg::DIVISOR_W-1:0]       scale_reg;

    gmos_pkg::q_stat_t  q_stat;
    gmos_pkg::item_t    push_item;
    gmos_pkg::item_t    pop_item;
    gmos_pkg::div_req_t div_req;
    gmos_pkg::div_rsp_t div_rsp;
    logic               push;
    logic               pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            scale_reg    <= gmos_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gmos_pkg::REG_BASELINE:
                begin
                    baseline_reg <= cfg_data;
                end
                gmos_pkg::REG_SCALE:
                begin
                    scale_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    gmos_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .last_sample (last_sample),
        .q_stat      (q_stat),
        .push        (push),
        .push_item   (push_item)
    );

    gmos_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    gmos_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gmos_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_item      (pop_item),
        .pop           (pop),
        .baseline      (baseline_reg),
        .scale_divisor (scale_reg),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .scaled_level  (scaled_level)
    );

    // divider is never restarted mid-division
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // divider completion is a single-cycle pulse
    a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |=> !div_rsp.done)
        else $error("divider done held for more than one cycle");

    // no transfer into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    // no pop from an empty queue, and no pop during a division
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!q_stat.empty && !div_rsp.busy))
        else $error("pop from empty queue or while dividing");

endmodule
